// File: hw/rtl/i2c_eeprom_byte_master_top_macros.svh
// Assertion macros shared by the RTL that checks itself in simulation.
// Both take a clock, a synchronous reset that masks the check, an antecedent
// and a consequent.
`ifndef I2C_EEPROM_BYTE_MASTER_TOP_MACROS_SVH
`define I2C_EEPROM_BYTE_MASTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define IEB_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ieb assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IEB_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ieb assertion failed");

`else

`define IEB_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define IEB_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

// File: hw/rtl/ieb_pkg.sv
package ieb_pkg;

  // One bus tick offered to the master.
  typedef struct packed {
    logic        cmd_valid;
    logic        mode;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
    logic        sda_in;
  } in_t;

  // Bus drives and status after one tick.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_result;
    logic       ack_missing;
    logic       bus_fault;
  } out_t;

  // Configuration seen by the sequencer.
  typedef struct packed {
    logic        two_byte_address;
    logic [15:0] phase_len;
  } cfg_t;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_TWO_BYTE_ADDRESS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_LEN        = 1'd1;

  localparam logic [15:0] PHASE_LEN_RESET = 16'd70;

  // Control bytes of the EEPROM device address.
  localparam logic [7:0] CTRL_WRITE = 8'hA0;
  localparam logic [7:0] CTRL_READ  = 8'hA1;

endpackage

// File: hw/rtl/i2c_eeprom_byte_master_top.sv
// Channel   Handshake        Payload
// request   push / full      item   (cmd_valid, mode, mem_address, write_data, sda_in)
// result    empty / pop      result (scl_out, sda_out, busy_res, done_res, ...)
// config    cfg_we           cfg_index, cfg_data
//
// Every request is one tick of the bus sequencer and yields exactly one result.
// With neither side stalled one request is taken every cycle; its result goes through
// the front and back queues to the result ports, where it waits to be popped.
// Reset (rst, synchronous) empties both queues and idles the sequencer with SCL
// and SDA released. A stalled result side backs up into the request queue,
// which raises full once both of its slots are taken.
`include "i2c_eeprom_byte_master_top_macros.svh"

module i2c_eeprom_byte_master_top import ieb_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  in_t                    item,
  output logic                   empty,
  input  logic                   pop,
  output out_t                   result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  in_t  head;
  out_t seq_result;
  logic front_empty;
  logic back_full;
  logic advance;

  // Configuration registers. Write them only while the block is idle; the block
  // itself does not enforce this, and the sequencer reads them directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.two_byte_address <= 1'b0;
      cfg.phase_len        <= PHASE_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TWO_BYTE_ADDRESS: cfg.two_byte_address <= cfg_data[0];
        CFG_PHASE_LEN: cfg.phase_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: queue of incoming requests.
  ieb_queue #(
    .T    (in_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .data_in (item),
    .pop     (advance),
    .empty   (front_empty),
    .data_out(head)
  );

  // The sequencer steps once for each request it takes from the front, as
  // long as the result queue has a free slot to hold what it produces.
  assign advance = !front_empty && !back_full;

  ieb_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .go    (advance),
    .item  (head),
    .result(seq_result)
  );

  // Back: queue of results waiting to be taken.
  ieb_queue #(
    .T    (out_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .push    (advance),
    .full    (back_full),
    .data_in (seq_result),
    .pop     (pop),
    .empty   (empty),
    .data_out(result)
  );

  // A request taken into an empty front queue is still waiting in the cycle after.
  `IEB_ASSERT_NEXT(a_front_holds, clk, rst, push && !full && front_empty, !front_empty)
  // The tick that completes STOP leaves the bus idle.
  `IEB_ASSERT_NOW(a_done_idle, clk, rst, !empty && result.done_res, !result.busy_res)

endmodule

// File: hw/rtl/ieb_queue.sv
module ieb_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  T     data_in,
  input  logic pop,
  output logic empty,
  output T     data_out
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  T                 slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/ieb_seq.sv
module ieb_seq import ieb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic go,
  input  in_t  item,
  output out_t result
);

  typedef enum logic [4:0] {
    S_IDLE, S_ST_A, S_ST_B, S_ST_C, S_TX_A, S_TX_B, S_TX_C,
    S_AK_A, S_AK_B, S_AK_C, S_AK_D, S_RX_A, S_RX_B,
    S_NA_A, S_NA_B, S_NA_C, S_NA_D, S_SP_A, S_SP_B, S_SP_C, S_SP_D
  } step_t;

  typedef enum logic [3:0] {
    G_START1, G_CTRL, G_HIGH, G_LOW, G_DATA, G_START2, G_RDCTRL, G_READ, G_STOP
  } stage_t;

  typedef struct packed {
    step_t       step;
    logic [15:0] timer;
    logic [3:0]  bitc;
    logic [7:0]  shift;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        mode;
    logic [7:0]  rbyte;
    logic        ack;
    logic        fault;
    stage_t      stage;
    logic        wide;
    logic        scl;
    logic        sda;
  } seq_t;

  seq_t        st;
  seq_t        st_next;
  logic        done_next;
  logic [16:0] tsum;

  // Start a bus phase and set its line drives.
  function automatic seq_t f_enter(seq_t s, step_t n);
    seq_t r;
    r = s;
    r.step  = n;
    r.timer = '0;
    case (n)
      S_ST_A: begin r.scl = 1'b1; r.sda = 1'b1; end
      S_ST_B, S_ST_C: begin r.scl = 1'b1; r.sda = 1'b0; end
      S_TX_A, S_AK_A, S_SP_A: r.scl = 1'b0;
      S_TX_B: begin r.scl = 1'b0; r.sda = r.shift[7]; end
      S_TX_C: r.scl = 1'b1;
      S_AK_B, S_AK_D, S_RX_A, S_NA_A, S_NA_B, S_NA_D: begin
        r.scl = 1'b0; r.sda = 1'b1;
      end
      S_AK_C, S_RX_B, S_NA_C, S_SP_D: begin r.scl = 1'b1; r.sda = 1'b1; end
      S_SP_B: begin r.scl = 1'b0; r.sda = 1'b0; end
      S_SP_C: begin r.scl = 1'b1; r.sda = 1'b0; end
      default: begin r.step = S_IDLE; r.scl = 1'b1; r.sda = 1'b1; end
    endcase
    return r;
  endfunction

  // Start a byte-level stage of the transaction.
  function automatic seq_t f_begin(seq_t s, stage_t g);
    seq_t  r;
    step_t first;
    r = s;
    r.stage = g;
    r.bitc  = '0;
    first   = S_TX_A;
    case (g)
      G_START1, G_START2: first = S_ST_A;
      G_CTRL: r.shift = r.wide ? CTRL_WRITE
                               : (CTRL_WRITE | {4'b0000, r.addr[10:8], 1'b0});
      G_HIGH: r.shift = r.addr[15:8];
      G_LOW: r.shift = r.addr[7:0];
      G_DATA: r.shift = r.data;
      G_RDCTRL: r.shift = CTRL_READ;
      G_READ: begin r.shift = '0; first = S_RX_A; end
      default: begin r.stage = G_STOP; first = S_SP_A; end
    endcase
    return f_enter(r, first);
  endfunction

  function automatic seq_t f_after_ack(seq_t s);
    stage_t g;
    case (s.stage)
      G_CTRL: g = s.wide ? G_HIGH : G_LOW;
      G_HIGH: g = G_LOW;
      G_LOW: g = s.mode ? G_START2 : G_DATA;
      G_RDCTRL: g = G_READ;
      default: g = G_STOP;
    endcase
    return f_begin(s, g);
  endfunction

  always_comb begin
    st_next   = st;
    done_next = 1'b0;
    tsum      = {1'b0, st.timer} + 17'd1;
    if (st.step == S_IDLE) begin
      if (item.cmd_valid) begin
        st_next.mode  = item.mode;
        st_next.addr  = item.mem_address;
        st_next.data  = item.write_data;
        st_next.wide  = cfg.two_byte_address;
        st_next.ack   = 1'b0;
        st_next.fault = 1'b0;
        st_next = f_begin(st_next, G_START1);
      end
    end else begin
      st_next.timer = tsum[15:0];
      if (tsum >= {1'b0, cfg.phase_len}) begin
        case (st.step)
          S_ST_A, S_ST_B, S_ST_C: begin
            if ((st.step == S_ST_A && !item.sda_in) ||
                (st.step == S_ST_B && item.sda_in)) begin
              st_next.fault = 1'b1;
            end
            if (st.step == S_ST_A && item.sda_in) begin
              st_next = f_enter(st_next, S_ST_B);
            end else if (st.step == S_ST_B && !item.sda_in) begin
              st_next = f_enter(st_next, S_ST_C);
            end else begin
              st_next = f_begin(st_next,
                                (st.stage == G_START2) ? G_RDCTRL : G_CTRL);
            end
          end
          S_TX_A: st_next = f_enter(st_next, S_TX_B);
          S_TX_B: st_next = f_enter(st_next, S_TX_C);
          S_TX_C: begin
            st_next.shift = {st.shift[6:0], 1'b0};
            st_next.bitc  = st.bitc + 4'd1;
            st_next = f_enter(st_next, (st_next.bitc >= 4'd8) ? S_AK_A : S_TX_A);
          end
          S_AK_A: st_next = f_enter(st_next, S_AK_B);
          S_AK_B: st_next = f_enter(st_next, S_AK_C);
          S_AK_C: begin
            if (item.sda_in) begin
              st_next.ack = 1'b1;
            end
            st_next = f_enter(st_next, S_AK_D);
          end
          S_AK_D: st_next = f_after_ack(st_next);
          S_RX_A: st_next = f_enter(st_next, S_RX_B);
          S_RX_B: begin
            st_next.shift = {st.shift[6:0], item.sda_in};
            st_next.bitc  = st.bitc + 4'd1;
            if (st_next.bitc >= 4'd8) begin
              st_next.rbyte = st_next.shift;
              st_next = f_enter(st_next, S_NA_A);
            end else begin
              st_next = f_enter(st_next, S_RX_A);
            end
          end
          S_NA_A: st_next = f_enter(st_next, S_NA_B);
          S_NA_B: st_next = f_enter(st_next, S_NA_C);
          S_NA_C: st_next = f_enter(st_next, S_NA_D);
          S_NA_D: st_next = f_begin(st_next, G_STOP);
          S_SP_A: st_next = f_enter(st_next, S_SP_B);
          S_SP_B: st_next = f_enter(st_next, S_SP_C);
          S_SP_C: st_next = f_enter(st_next, S_SP_D);
          S_SP_D: begin
            st_next   = f_enter(st_next, S_IDLE);
            done_next = 1'b1;
          end
          default: st_next = f_enter(st_next, S_IDLE);
        endcase
      end
    end
  end

  always_comb begin
    result.scl_out     = st_next.scl;
    result.sda_out     = st_next.sda;
    result.busy_res    = (st_next.step != S_IDLE);
    result.done_res    = done_next;
    result.read_result = st_next.rbyte;
    result.ack_missing = st_next.ack;
    result.bus_fault   = st_next.fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.step  <= S_IDLE;
      st.timer <= '0;
      st.bitc  <= '0;
      st.shift <= '0;
      st.addr  <= '0;
      st.data  <= '0;
      st.mode  <= 1'b0;
      st.rbyte <= '0;
      st.ack   <= 1'b0;
      st.fault <= 1'b0;
      st.stage <= G_START1;
      st.wide  <= 1'b0;
      st.scl   <= 1'b1;
      st.sda   <= 1'b1;
    end else if (go) begin
      st <= st_next;
    end
  end

endmodule
